@@ rtl/core/line_rasterizer_solid_dashed_unit_assert.svh @@
// Assertion macros for the line rasteriser RTL
`ifndef LINE_RASTERIZER_SOLID_DASHED_UNIT_ASSERT_SVH
`define LINE_RASTERIZER_SOLID_DASHED_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define LRSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LRSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/lrsd_pkg.sv @@
// Types and constants shared by the line rasteriser modules
`default_nettype none
package lrsd_pkg;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } lrsd_kind_t;

    localparam int unsigned COLOUR_BITS = 16;
    localparam int unsigned DASH_BITS   = 4;
    localparam int unsigned DASH_PERIOD = 10;
    localparam logic [DASH_BITS-1:0] DASH_ON_MAX = 4'd4;

    typedef struct packed {
        logic draw;
        logic last_pixel;
        logic idle;
    } lrsd_flags_t;

endpackage
`default_nettype wire

@@ rtl/core/lrsd_engine.sv @@
// Bresenham line state and one-iteration step logic
`default_nettype none
module lrsd_engine
    import lrsd_pkg::*;
#(
    parameter int COORD_BITS = 9
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   fire,
    input  wire lrsd_kind_t             kind,
    input  wire logic [COORD_BITS-1:0]  start_x,
    input  wire logic [COORD_BITS-1:0]  start_y,
    input  wire logic [COORD_BITS-1:0]  end_x,
    input  wire logic [COORD_BITS-1:0]  end_y,
    input  wire logic [COLOUR_BITS-1:0] colour,
    input  wire logic                   dashed,
    output logic [COORD_BITS-1:0]       pixel_x,
    output logic [COORD_BITS-1:0]       pixel_y,
    output logic [COLOUR_BITS-1:0]      pixel_colour,
    output lrsd_flags_t                 flags
);

    localparam int EB = COORD_BITS + 2;

    logic [COORD_BITS-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_reg, cur_y_next;
    logic [EB-1:0]          err_reg, err_next;
    logic [COORD_BITS-1:0]  major_reg, major_next;
    logic [COORD_BITS-1:0]  minor_reg, minor_next;
    logic [COORD_BITS-1:0]  count_reg, count_next;
    logic [DASH_BITS-1:0]   phase_reg, phase_next;
    logic                   x_neg_reg, x_neg_next;
    logic                   y_neg_reg, y_neg_next;
    logic                   steep_reg, steep_next;
    logic [COLOUR_BITS-1:0] colour_reg, colour_next;
    logic                   dash_reg, dash_next;
    logic                   busy_reg, busy_next;

    logic                   x_neg_c, y_neg_c, steep_c;
    logic [COORD_BITS-1:0]  adx_c, ady_c, major_c, minor_c;
    logic [COORD_BITS:0]    count_inc;
    logic [DASH_BITS:0]     phase_inc;
    logic [EB:0]            err_wide;
    logic                   last_c;
    logic [COORD_BITS-1:0]  x_step, y_step;

    // Set-up arithmetic for a start transaction
    always_comb begin
        x_neg_c = end_x < start_x;
        y_neg_c = end_y < start_y;
        adx_c   = x_neg_c ? start_x - end_x : end_x - start_x;
        ady_c   = y_neg_c ? start_y - end_y : end_y - start_y;
        steep_c = ady_c > adx_c;
        major_c = steep_c ? ady_c : adx_c;
        minor_c = steep_c ? adx_c : ady_c;
    end

    // Per-iteration arithmetic on the held line
    always_comb begin
        count_inc = {1'b0, count_reg} + {{COORD_BITS{1'b0}}, 1'b1};
        last_c    = count_inc >= {1'b0, major_reg};
        phase_inc = {1'b0, phase_reg} + {{DASH_BITS{1'b0}}, 1'b1};
        x_step    = x_neg_reg ? cur_x_reg - {{(COORD_BITS-1){1'b0}}, 1'b1}
                              : cur_x_reg + {{(COORD_BITS-1){1'b0}}, 1'b1};
        y_step    = y_neg_reg ? cur_y_reg - {{(COORD_BITS-1){1'b0}}, 1'b1}
                              : cur_y_reg + {{(COORD_BITS-1){1'b0}}, 1'b1};
        err_wide  = {err_reg[EB-1], err_reg} + {2'b00, minor_reg, 1'b0};
        if (!err_reg[EB-1]) begin
            err_wide = err_wide - {2'b00, major_reg, 1'b0};
        end
    end

    always_comb begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        err_next    = err_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        steep_next  = steep_reg;
        colour_next = colour_reg;
        dash_next   = dash_reg;
        busy_next   = busy_reg;

        pixel_x      = '0;
        pixel_y      = '0;
        pixel_colour = '0;
        flags        = '0;

        if (kind == KIND_START) begin
            // Drop any line in progress and load the new one
            x_neg_next  = x_neg_c;
            y_neg_next  = y_neg_c;
            steep_next  = steep_c;
            major_next  = major_c;
            minor_next  = minor_c;
            err_next    = {1'b0, minor_c, 1'b0} - {2'b00, major_c};
            cur_x_next  = start_x;
            cur_y_next  = start_y;
            colour_next = colour;
            dash_next   = dashed;
            count_next  = '0;
            phase_next  = '0;
            busy_next   = major_c != '0;
            flags.idle  = major_c == '0;
        end else if (!busy_reg) begin
            flags.idle = 1'b1;
        end else begin
            pixel_x          = cur_x_reg;
            pixel_y          = cur_y_reg;
            pixel_colour     = colour_reg;
            flags.draw       = !dash_reg || (phase_reg <= DASH_ON_MAX);
            flags.last_pixel = last_c;
            flags.idle       = last_c;

            if (steep_reg) begin
                cur_y_next = y_step;
                if (!err_reg[EB-1]) cur_x_next = x_step;
            end else begin
                cur_x_next = x_step;
                if (!err_reg[EB-1]) cur_y_next = y_step;
            end
            err_next   = err_wide[EB-1:0];
            count_next = count_inc[COORD_BITS-1:0];
            phase_next = (phase_inc >= (DASH_BITS+1)'(DASH_PERIOD)) ? '0
                                                                  : phase_inc[DASH_BITS-1:0];
            if (last_c) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            err_reg    <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            count_reg  <= '0;
            phase_reg  <= '0;
            x_neg_reg  <= 1'b0;
            y_neg_reg  <= 1'b0;
            steep_reg  <= 1'b0;
            colour_reg <= '0;
            dash_reg   <= 1'b0;
            busy_reg   <= 1'b0;
        end else if (fire) begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            err_reg    <= err_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            x_neg_reg  <= x_neg_next;
            y_neg_reg  <= y_neg_next;
            steep_reg  <= steep_next;
            colour_reg <= colour_next;
            dash_reg   <= dash_next;
            busy_reg   <= busy_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/line_rasterizer_solid_dashed_unit.sv @@
// Top level of the solid/dashed Bresenham line rasteriser
//
//  channel  ports             tdata (lowest bit up)                       side band
//  input    s_tvalid/tready   start_x start_y end_x end_y colour dashed   tuser: kind
//  output   m_tvalid/tready   pixel_x pixel_y pixel_colour draw idle      tlast: last_pixel
//
// One transaction in, one transaction out; a new item is taken every cycle while the output is not stalled.
// Each item passes through the input register, then the step logic into the result register.
// The throughput is set by the single line-state register bank updated per item.
// aresetn is synchronous; reset leaves the rasteriser idle with all line state cleared.
// A stalled output holds the result; one more item waits in the input register.
`default_nettype none
`include "line_rasterizer_solid_dashed_unit_assert.svh"
module line_rasterizer_solid_dashed_unit
    import lrsd_pkg::*;
#(
    parameter int COORD_BITS = 9
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // start_x, start_y, end_x, end_y, colour, dashed (lowest bit up), zero fill
    input  wire logic [((4*COORD_BITS+COLOUR_BITS+1+7)/8)*8-1:0] s_tdata,
    // kind
    input  wire logic                       s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // pixel_x, pixel_y, pixel_colour, draw, idle (lowest bit up), zero fill
    output logic [((2*COORD_BITS+COLOUR_BITS+2+7)/8)*8-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int CB        = COORD_BITS;
    localparam int IN_USED   = 4*CB + COLOUR_BITS + 1;
    localparam int OUT_USED  = 2*CB + COLOUR_BITS + 2;
    localparam int OUT_BITS  = ((OUT_USED + 7) / 8) * 8;

    logic                   in_valid_reg;
    lrsd_kind_t             in_kind_reg;
    logic [IN_USED-1:0]     in_data_reg;

    logic                   m_valid_reg;
    logic [CB-1:0]          m_x_reg;
    logic [CB-1:0]          m_y_reg;
    logic [COLOUR_BITS-1:0] m_colour_reg;
    lrsd_flags_t            m_flags_reg;

    logic                   advance;
    logic                   fire;
    logic [CB-1:0]          res_x;
    logic [CB-1:0]          res_y;
    logic [COLOUR_BITS-1:0] res_colour;
    lrsd_flags_t            res_flags;

    assign advance  = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload capture: hold while the input register is blocked
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= lrsd_kind_t'(s_tuser);
            in_data_reg <= s_tdata[IN_USED-1:0];
        end
    end

    lrsd_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .kind         (in_kind_reg),
        .start_x      (in_data_reg[CB-1:0]),
        .start_y      (in_data_reg[2*CB-1:CB]),
        .end_x        (in_data_reg[3*CB-1:2*CB]),
        .end_y        (in_data_reg[4*CB-1:3*CB]),
        .colour       (in_data_reg[4*CB+COLOUR_BITS-1:4*CB]),
        .dashed       (in_data_reg[IN_USED-1]),
        .pixel_x      (res_x),
        .pixel_y      (res_y),
        .pixel_colour (res_colour),
        .flags        (res_flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_x_reg      <= res_x;
            m_y_reg      <= res_y;
            m_colour_reg <= res_colour;
            m_flags_reg  <= res_flags;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_flags_reg.last_pixel;
    assign m_tdata  = {{(OUT_BITS-OUT_USED){1'b0}}, m_flags_reg.idle, m_flags_reg.draw,
                       m_colour_reg, m_y_reg, m_x_reg};

    // The final pixel of a line always leaves the rasteriser idle
    `LRSD_ASSERT_NOW(a_last_is_idle, aclk, aresetn, m_valid_reg && m_flags_reg.last_pixel,
                     m_flags_reg.idle, "last pixel reported without going idle")

    // A drawn pixel that reports idle must be the last one of its line
    `LRSD_ASSERT_NOW(a_draw_idle_last, aclk, aresetn,
                     m_valid_reg && m_flags_reg.draw && m_flags_reg.idle,
                     m_flags_reg.last_pixel, "idle after a drawn pixel that is not last")

    // A blocked input register keeps its item until the result side frees up
    `LRSD_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance,
                      in_valid_reg && $stable(in_data_reg) && $stable(in_kind_reg),
                      "input register lost an item while stalled")

endmodule
`default_nettype wire
